>>> rtl/u8gf_pkg.sv
// Shared types, constants and glyph lookup functions for the UTF-8 ASCII fallback unit.
package u8gf_pkg;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
    localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

    // Lead byte masks and patterns
    localparam logic [7:0] Lead2Mask = 8'hE0;
    localparam logic [7:0] Lead2Code = 8'hC0;
    localparam logic [7:0] Lead3Mask = 8'hF0;
    localparam logic [7:0] Lead3Code = 8'hE0;
    localparam logic [7:0] Lead4Mask = 8'hF8;
    localparam logic [7:0] Lead4Code = 8'hF0;
    localparam logic [7:0] ContMask  = 8'hC0;
    localparam logic [7:0] ContCode  = 8'h80;

    // One step's worth of result bytes, up to four
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [1:0]      len;
        logic [2:0][7:0] str;
    } glyph_t;

    function automatic glyph_t glyph1(input logic [7:0] c0);
        glyph_t g;
        g.len = 2'd1;
        g.str = {8'h00, 8'h00, c0};
        return g;
    endfunction

    function automatic glyph_t glyph2(input logic [7:0] c0, input logic [7:0] c1);
        glyph_t g;
        g.len = 2'd2;
        g.str = {8'h00, c1, c0};
        return g;
    endfunction

    function automatic glyph_t glyph3(input logic [7:0] c0, input logic [7:0] c1,
                                      input logic [7:0] c2);
        glyph_t g;
        g.len = 2'd3;
        g.str = {c2, c1, c0};
        return g;
    endfunction

    // Priority matters: the first matching arm wins.
    function automatic glyph_t glyph_lookup(input logic [20:0] cp);
        glyph_t g;
        case (cp) inside
            21'h2500, 21'h2501, 21'h2504, 21'h2505, 21'h2508, 21'h2509, 21'h254C,
            21'h254D, 21'h2550, 21'h2013, 21'h2014: g = glyph1(8'h2D);
            21'h2502, 21'h2503, 21'h2506, 21'h2507, 21'h250A, 21'h250B, 21'h254E,
            21'h254F, 21'h2551: g = glyph1(8'h7C);
            [21'h250C:21'h254B], [21'h2552:21'h2570], 21'h271A: g = glyph1(8'h2B);
            [21'h2580:21'h259F]: g = glyph1(8'h23);
            21'h25A0, 21'h25A1: g = glyph2(8'h5B, 8'h5D);
            21'h25CF, 21'h25CB, 21'h25C9, 21'h25CE: g = glyph1(8'h6F);
            21'h25B6, 21'h25BA, 21'h25B8, 21'h2B95: g = glyph1(8'h3E);
            21'h25C0, 21'h25C4, 21'h25C2: g = glyph1(8'h3C);
            21'h25B2, 21'h25B4, 21'h2191, [21'h2B00:21'h2B0F]: g = glyph1(8'h5E);
            21'h25BC, 21'h25BE, 21'h2193, 21'h2713, 21'h2714,
            [21'h2B10:21'h2B1F]: g = glyph1(8'h76);
            21'h2190: g = glyph2(8'h3C, 8'h2D);
            21'h2192: g = glyph2(8'h2D, 8'h3E);
            21'h2194: g = glyph3(8'h3C, 8'h2D, 8'h3E);
            21'h21D0: g = glyph2(8'h3C, 8'h3D);
            21'h21D2: g = glyph2(8'h3D, 8'h3E);
            21'h21B5: g = glyph2(8'h5C, 8'h6E);
            21'h00B7, 21'h2027, 21'h2218, 21'h2219: g = glyph1(8'h2E);
            21'h2026: g = glyph3(8'h2E, 8'h2E, 8'h2E);
            21'h2717, 21'h2718, 21'h274C, 21'h274E: g = glyph1(8'h78);
            21'h2762: g = glyph1(8'h21);
            21'h2018, 21'h2019: g = glyph1(8'h27);
            21'h201C, 21'h201D: g = glyph1(8'h22);
            21'h00A0: g = glyph1(8'h20);
            21'h2022, [21'h2700:21'h27BF]: g = glyph1(8'h2A);
            default: g = '0;
        endcase
        return g;
    endfunction

    // A lone byte maps to exactly one byte: only NBSP and middle dot change.
    function automatic logic [7:0] lone_map(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'hA0:   r = 8'h20;
            8'hB7:   r = 8'h2E;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/u8gf_front.sv
// Front end: accept bytes, track the pending UTF-8 sequence, build result jobs.
module u8gf_front
    import u8gf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_chunk_end,
    input  q_stat_t    q_stat,
    output logic       q_push,
    output job_t       q_job
);

    logic [2:0][7:0] pend_reg, pend_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [2:0]      len_reg, len_next;

    logic            accept;
    logic            is_cont;
    logic [2:0]      lead_len;
    logic            active;
    logic [1:0]      ecnt;
    logic            finish;
    logic            store;
    logic            hold_new;
    logic [20:0]     cp;
    glyph_t          g;
    logic [3:0][7:0] flush_bytes;
    logic [3:0][7:0] raw_bytes;
    logic [7:0]      lone_b;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign is_cont = (s_in_byte & ContMask) == ContCode;

    always_comb begin
        if ((s_in_byte & Lead2Mask) == Lead2Code) begin
            lead_len = 3'd2;
        end else if ((s_in_byte & Lead3Mask) == Lead3Code) begin
            lead_len = 3'd3;
        end else if ((s_in_byte & Lead4Mask) == Lead4Code) begin
            lead_len = 3'd4;
        end else begin
            lead_len = 3'd0;
        end
    end

    assign active   = (cnt_reg != 2'd0) && (len_reg > {1'b0, cnt_reg});
    assign ecnt     = active ? cnt_reg : 2'd0;
    assign finish   = active && is_cont && (({1'b0, cnt_reg} + 3'd1) == len_reg);
    assign store    = active && is_cont && !finish && (cnt_reg != 2'd3);
    assign hold_new = !(active && is_cont) && (lead_len != 3'd0) && !s_chunk_end;
    assign lone_b   = lone_map(s_in_byte);

    // Flushed bytes first, then the current byte as a lone byte
    always_comb begin
        flush_bytes[0] = (ecnt > 2'd0) ? lone_map(pend_reg[0]) : lone_b;
        flush_bytes[1] = (ecnt > 2'd1) ? lone_map(pend_reg[1]) : lone_b;
        flush_bytes[2] = (ecnt > 2'd2) ? lone_map(pend_reg[2]) : lone_b;
        flush_bytes[3] = lone_b;
        raw_bytes[0]   = (cnt_reg > 2'd0) ? pend_reg[0] : s_in_byte;
        raw_bytes[1]   = (cnt_reg > 2'd1) ? pend_reg[1] : s_in_byte;
        raw_bytes[2]   = (cnt_reg > 2'd2) ? pend_reg[2] : s_in_byte;
        raw_bytes[3]   = s_in_byte;
    end

    always_comb begin
        case (cnt_reg)
            2'd1:    cp = {10'd0, pend_reg[0][4:0], s_in_byte[5:0]};
            2'd2:    cp = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0], s_in_byte[5:0]};
            2'd3:    cp = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0],
                           s_in_byte[5:0]};
            default: cp = '0;
        endcase
        g = glyph_lookup(cp);
    end

    always_comb begin
        pend_next = pend_reg;
        cnt_next  = 2'd0;
        len_next  = 3'd0;
        q_job     = '0;
        if (finish) begin
            if (g.len != 2'd0) begin
                q_job.bytes = {8'h00, g.str};
                q_job.cnt   = {1'b0, g.len};
            end else begin
                q_job.bytes = raw_bytes;
                q_job.cnt   = {1'b0, cnt_reg} + 3'd1;
            end
        end else if (store) begin
            pend_next[cnt_reg] = s_in_byte;
            if (s_chunk_end) begin
                q_job.bytes = flush_bytes;
                q_job.cnt   = {1'b0, cnt_reg} + 3'd1;
            end else begin
                cnt_next = cnt_reg + 2'd1;
                len_next = len_reg;
            end
        end else begin
            q_job.bytes = flush_bytes;
            if (hold_new) begin
                q_job.cnt    = {1'b0, ecnt};
                pend_next[0] = s_in_byte;
                cnt_next     = 2'd1;
                len_next     = lead_len;
            end else begin
                q_job.cnt = {1'b0, ecnt} + 3'd1;
            end
        end
    end

    assign q_push = accept && (q_job.cnt != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            len_reg <= 3'd0;
        end else if (accept) begin
            cnt_reg <= cnt_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg <= pend_next;
        end
    end

endmodule

>>> rtl/u8gf_queue.sv
// Short job queue between the front end and the output serializer.
module u8gf_queue
    import u8gf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head,
    output q_stat_t stat
);

    job_t                 mem_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueueCntW-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == QueueCntW'(QueueDepth));
    assign stat.empty = (count_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/u8gf_back.sv
// Back end: serialize queued jobs into the registered result channel.
module u8gf_back
    import u8gf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  q_stat_t    q_stat,
    input  job_t       q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last
);

    logic [1:0] idx_reg;
    logic       m_valid_reg;
    logic [7:0] m_out_byte_reg;
    logic       m_run_last_reg;
    logic       load;
    logic       last_byte;

    assign load      = !m_valid_reg || m_ready;
    assign last_byte = (({1'b0, idx_reg} + 3'd1) == q_head.cnt);
    assign q_pop     = load && !q_stat.empty && last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end else if (load) begin
            m_valid_reg <= !q_stat.empty;
            if (!q_stat.empty) begin
                idx_reg <= last_byte ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_out_byte_reg <= q_head.bytes[idx_reg];
            m_run_last_reg <= last_byte;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_run_last = m_run_last_reg;

endmodule

>>> rtl/utf8_glyph_ascii_fallback_unit.sv
// Top level of the UTF-8 glyph to ASCII fallback unit.
//
// Input channel (s_): one text byte per transfer, with s_chunk_end marking
// the last byte of a chunk. Output channel (m_): one rewritten byte per
// transfer; m_run_last marks the last byte produced by one input byte.
// An input byte that only extends a pending UTF-8 sequence produces no
// output transfer at all; one input byte produces at most four.
//
// Path: an input's first output byte passes the job queue, then the output
// register. Throughput: one input byte per cycle while each input yields at
// most one output byte and m_ready stays high; the serializer moves one byte
// per cycle while m_ready is high and stays on a job until its last byte. A
// two-entry job queue sits between the decoder and the serializer, so the
// input keeps flowing while a finished byte waits in the output register.
//
// Reset (aresetn low at a clock edge) drops any pending sequence, empties
// the queue and clears m_valid. When the receiver stalls, the output holds
// its byte, the queue fills and then s_ready falls until space frees up.
module utf8_glyph_ascii_fallback_unit
    import u8gf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_chunk_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last
);

    q_stat_t q_stat;
    job_t    push_job;
    job_t    head_job;
    logic    q_push;
    logic    q_pop;

    // Decode and classify: hold partial sequences, build the job for each byte
    u8gf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_chunk_end (s_chunk_end),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    // Decouple decoder stalls from output stalls
    u8gf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (head_job),
        .stat     (q_stat)
    );

    // Advance through each job one byte per output transfer
    u8gf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .q_head     (head_job),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last)
    );

endmodule

>>> rtl/u8gf_checker.sv
// Port-level checker for the UTF-8 glyph to ASCII fallback unit, with its bind.
module u8gf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_in_byte,
    input logic       s_chunk_end,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_run_last
);

    // Reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // Reset empties the queue, so input is taken right away
    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("s_ready low after reset");

    // A waiting input transfer keeps its byte and chunk flag
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_in_byte) && $stable(s_chunk_end))
        else $error("input changed while waiting");

    // Stalled output holds its byte
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_run_last))
        else $error("output changed while stalled");

    // Bytes of one run follow each other without gaps
    a_run_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=> m_valid)
        else $error("gap inside an output run");

endmodule

bind utf8_glyph_ascii_fallback_unit u8gf_checker u_u8gf_checker (.*);

>>> sim/tb_utf8_glyph_ascii_fallback_unit.sv
// Self-checking testbench for the UTF-8 glyph to ASCII fallback unit.
module tb_utf8_glyph_ascii_fallback_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomBytes = 500;
    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 16;

    // One rewritten byte as it should leave the block.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } text_beat_t;

    // Tracks the decoder state of the block and holds the rewritten bytes
    // still owed on the output channel, oldest first.
    class rewrite_scoreboard;
        text_beat_t owed_q[$];
        logic [7:0] held[3];
        int         held_cnt;
        int         seq_len;
        logic [7:0] step_out[$];
        int         faults;

        function new();
            held_cnt = 0;
            seq_len  = 0;
            faults   = 0;
        endfunction

        // ASCII stand-in for a code point, empty when the glyph is kept.
        function string glyph_text(int unsigned cp);
            string r;
            case (cp) inside
                32'h2500, 32'h2501, 32'h2504, 32'h2505, 32'h2508, 32'h2509,
                32'h254C, 32'h254D, 32'h2550, 32'h2013, 32'h2014: r = "-";
                32'h2502, 32'h2503, 32'h2506, 32'h2507, 32'h250A, 32'h250B,
                32'h254E, 32'h254F, 32'h2551: r = "|";
                [32'h250C:32'h254B], [32'h2552:32'h2570], 32'h271A: r = "+";
                [32'h2580:32'h259F]: r = "#";
                32'h25A0, 32'h25A1: r = "[]";
                32'h25CF, 32'h25CB, 32'h25C9, 32'h25CE: r = "o";
                32'h25B6, 32'h25BA, 32'h25B8, 32'h2B95: r = ">";
                32'h25C0, 32'h25C4, 32'h25C2: r = "<";
                32'h25B2, 32'h25B4, 32'h2191, [32'h2B00:32'h2B0F]: r = "^";
                32'h25BC, 32'h25BE, 32'h2193, 32'h2713, 32'h2714,
                [32'h2B10:32'h2B1F]: r = "v";
                32'h2190: r = "<-";
                32'h2192: r = "->";
                32'h2194: r = "<->";
                32'h21D0: r = "<=";
                32'h21D2: r = "=>";
                32'h21B5: r = "\\n";
                32'h00B7, 32'h2027, 32'h2218, 32'h2219: r = ".";
                32'h2026: r = "...";
                32'h2717, 32'h2718, 32'h274C, 32'h274E: r = "x";
                32'h2762: r = "!";
                32'h2018, 32'h2019: r = "'";
                32'h201C, 32'h201D: r = "\"";
                32'h00A0: r = " ";
                32'h2022, [32'h2700:32'h27BF]: r = "*";
                default: r = "";
            endcase
            return r;
        endfunction

        function void put(logic [7:0] b);
            if (step_out.size() < 4) step_out = {step_out, b};
        endfunction

        function void put_lone(logic [7:0] b);
            string rep;
            rep = (b >= 8'h80) ? glyph_text(b) : "";
            if (rep.len() == 0) begin
                put(b);
            end else begin
                for (int k = 0; k < rep.len(); k++) put(rep[k]);
            end
        endfunction

        function void flush_held();
            for (int k = 0; k < held_cnt; k++) put_lone(held[k]);
            held_cnt = 0;
            seq_len  = 0;
        endfunction

        function void start_lead(logic [7:0] b, logic e);
            int n;
            if (b[7:5] == 3'b110) n = 2;
            else if (b[7:4] == 4'b1110) n = 3;
            else if (b[7:3] == 5'b11110) n = 4;
            else n = 0;
            if (n == 0 || e) begin
                put_lone(b);
            end else begin
                held[0]  = b;
                held_cnt = 1;
                seq_len  = n;
            end
        endfunction

        // Advance the decoder by one accepted byte and queue what it owes.
        function void note_input(logic [7:0] b, logic e);
            logic [7:0]  seq[4];
            int unsigned cp;
            string       rep;
            int          n;
            text_beat_t  beat;
            step_out.delete();
            if (held_cnt > 0 && seq_len > held_cnt) begin
                if (b[7:6] == 2'b10) begin
                    if (held_cnt + 1 == seq_len) begin
                        n = seq_len;
                        for (int k = 0; k < held_cnt; k++) seq[k] = held[k];
                        seq[n-1] = b;
                        if (n == 2) cp = int'(seq[0][4:0]) << 6;
                        else if (n == 3) cp = int'(seq[0][3:0]) << 12;
                        else cp = int'(seq[0][2:0]) << 18;
                        for (int k = 1; k < n; k++)
                            cp |= int'(seq[k][5:0]) << (6 * (n - 1 - k));
                        rep = (cp >= 32'h80) ? glyph_text(cp) : "";
                        if (rep.len() > 0) begin
                            for (int k = 0; k < rep.len(); k++) put(rep[k]);
                        end else begin
                            for (int k = 0; k < n; k++) put(seq[k]);
                        end
                        held_cnt = 0;
                        seq_len  = 0;
                    end else if (held_cnt < 3) begin
                        held[held_cnt] = b;
                        held_cnt++;
                        if (e) flush_held();
                    end else begin
                        flush_held();
                        put_lone(b);
                    end
                end else begin
                    flush_held();
                    start_lead(b, e);
                end
            end else begin
                held_cnt = 0;
                seq_len  = 0;
                start_lead(b, e);
            end
            foreach (step_out[k]) begin
                beat.data = step_out[k];
                beat.last = (k == step_out.size() - 1);
                owed_q = {owed_q, beat};
            end
        endfunction

        // Compare one output transfer against the oldest owed byte.
        function void check_output(logic [7:0] b, logic last);
            text_beat_t want;
            if (owed_q.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected output: got %02h last %0b", b, last);
                return;
            end
            want = owed_q.pop_front();
            if (b !== want.data || last !== want.last) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: expected %02h last %0b, got %02h last %0b",
                             want.data, want.last, b, last);
            end
        endfunction
    endclass

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte   = 8'h00;
    logic       s_chunk_end = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_run_last;

    rewrite_scoreboard board = new();

    int cycle_cnt = 0;
    int sent      = 0;
    bit tx_calm   = 1'b0;
    bit rx_calm   = 1'b0;

    utf8_glyph_ascii_fallback_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_chunk_end (s_chunk_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_run_last  (m_run_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run; the bound is many times the slowest legal run.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CycleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sample both channels at the edge. Check the output before noting the
    // input so a result can never match a byte taken in the same cycle.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) board.check_output(m_out_byte, m_run_last);
            if (s_valid && s_ready) board.note_input(s_in_byte, s_chunk_end);
        end
    end

    // Receiver: per result, hold ready low for a random stall, then raise it
    // and keep it high until the transfer. Calm stretches drop the stalls.
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Drive one input byte: idle a random gap, then hold valid and payload
    // until the transfer. A zero gap keeps valid high across items.
    task automatic push_byte(input logic [7:0] b, input logic e);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_in_byte   <= b;
        s_chunk_end <= e;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // Rarely cut a chunk, so sequences also get truncated mid-way.
    function automatic logic rand_end();
        return $urandom_range(0, 15) == 0;
    endfunction

    // Encode a code point in the given length (overlong forms allowed).
    task automatic send_code_point(input logic [20:0] cp, input int len);
        logic [7:0] b[4];
        case (len)
            2: begin
                b[0] = {3'b110, cp[10:6]};
                b[1] = {2'b10, cp[5:0]};
            end
            3: begin
                b[0] = {4'b1110, cp[15:12]};
                b[1] = {2'b10, cp[11:6]};
                b[2] = {2'b10, cp[5:0]};
            end
            default: begin
                b[0] = {5'b11110, cp[20:18]};
                b[1] = {2'b10, cp[17:12]};
                b[2] = {2'b10, cp[11:6]};
                b[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int k = 0; k < len; k++) push_byte(b[k], rand_end());
    endtask

    initial begin
        int         kind;
        int         len;
        int         conts;
        logic [7:0] lead;
        logic [20:0] cp;

        // Hold reset low at start-up, then release it once.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: ASCII extremes, lone-byte rewrites, stray and invalid
        // bytes, two- and three-byte table hits, pass-through and overlong
        // forms, a broken four-byte sequence and chunk cuts.
        push_byte(8'h00, 1'b1);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hA0, 1'b0);
        push_byte(8'hB7, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hF8, 1'b0);
        send_code_point(21'h00A0, 2);
        send_code_point(21'h2500, 3);
        send_code_point(21'h2194, 3);
        send_code_point(21'h1F600, 4);
        send_code_point(21'h0041, 2);
        // Broken: lead, two continuations, then plain ASCII.
        push_byte(8'hF0, 1'b0);
        push_byte(8'h9F, 1'b0);
        push_byte(8'hA0, 1'b0);
        push_byte(8'h41, 1'b0);
        // Chunk ends after a continuation, then on a lead byte.
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b1);
        push_byte(8'hC3, 1'b1);

        // Random: mostly well-formed text with random content, some noise
        // and some sequences broken on purpose.
        while (sent < 20 + RandomBytes) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: push_byte(8'($urandom_range(0, 127)), rand_end());
                2, 3, 4: begin
                    case ($urandom_range(0, 6))
                        0: cp = 21'h2500 + 21'($urandom_range(0, 255));
                        1: cp = 21'h2000 + 21'($urandom_range(0, 63));
                        2: cp = 21'h2180 + 21'($urandom_range(0, 95));
                        3: cp = 21'h2700 + 21'($urandom_range(0, 255));
                        4: cp = 21'h2B00 + 21'($urandom_range(0, 159));
                        5: cp = 21'h2210 + 21'($urandom_range(0, 15));
                        default: cp = 21'h0080 + 21'($urandom_range(0, 127));
                    endcase
                    send_code_point(cp, (cp < 21'h800) ? 2 : 3);
                end
                5: send_code_point(21'($urandom_range(0, 32'h7FF)), 2);
                6: send_code_point(21'($urandom_range(0, 32'hFFFF)), 3);
                7: send_code_point(21'($urandom_range(0, 32'h1FFFFF)), 4);
                8: push_byte(8'($urandom_range(0, 255)), rand_end());
                default: begin
                    len = $urandom_range(2, 4);
                    lead = 8'($urandom_range(0, 255));
                    if (len == 2) lead[7:5] = 3'b110;
                    else if (len == 3) lead[7:4] = 4'b1110;
                    else lead[7:3] = 5'b11110;
                    push_byte(lead, 1'b0);
                    conts = $urandom_range(0, len - 2);
                    for (int k = 0; k < conts; k++)
                        push_byte({2'b10, 6'($urandom_range(0, 63))}, 1'b0);
                    // Break it with ASCII or a byte at C0 or above.
                    if ($urandom_range(0, 1) == 0)
                        push_byte(8'($urandom_range(0, 127)), rand_end());
                    else
                        push_byte(8'($urandom_range(8'hC0, 8'hFF)), rand_end());
                end
            endcase
        end
        s_valid <= 1'b0;

        // Let the sampler note the last transfer, then wait for every owed
        // byte and a few idle cycles to catch anything extra.
        @(posedge aclk);
        while (board.owed_q.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        if (board.faults == 0 && board.owed_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
rtl/u8gf_pkg.sv
rtl/u8gf_front.sv
rtl/u8gf_queue.sv
rtl/u8gf_back.sv
rtl/utf8_glyph_ascii_fallback_unit.sv
rtl/u8gf_checker.sv
sim/tb_utf8_glyph_ascii_fallback_unit.sv
